>>> rtl/rdsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit string converter package
// Shared constants, the sequencer state type and the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package rdsc_pkg;

  localparam int unsigned NumW       = 32;
  localparam int unsigned RadixW     = 6;
  localparam int unsigned DigitW     = 6;
  localparam int unsigned CharW      = 7;
  localparam int unsigned OutTdataW  = 8;
  localparam int unsigned ChunkW     = 8;

  localparam logic [RadixW-1:0] RadixMin   = 6'd2;
  localparam logic [RadixW-1:0] RadixMax   = 6'd36;
  localparam logic [RadixW-1:0] RadixReset = 6'd2;
  localparam logic [DigitW-1:0] DecLimit   = 6'd10;
  localparam logic [CharW-1:0]  CharZero   = 7'd48;
  localparam logic [CharW-1:0]  AlphaOfs   = 7'd55;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StCheck = 5'b00010,
    StDiv   = 5'b00100,
    StRead  = 5'b01000,
    StLoad  = 5'b10000
  } state_e;

  function automatic logic [CharW-1:0] to_ascii(input logic [DigitW-1:0] d);
    logic [CharW-1:0] c;
    if (d < DecLimit) begin
      c = CharW'(d) + CharZero;
    end else begin
      c = CharW'(d) + AlphaOfs;
    end
    return c;
  endfunction

endpackage

>>> rtl/rdsc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit string converter divider
// Shared restoring divider that retires one chunk of quotient bits a cycle.
// ----------------------------------------------------------------------------
module rdsc_divider #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [VALUE_BITS-1:0]             dividend_i,
  input  logic [rdsc_pkg::RadixW-1:0]       divisor_i,
  output logic                              done_o,
  output logic [VALUE_BITS-1:0]             quotient_o,
  output logic [rdsc_pkg::DigitW-1:0]       remainder_o
);

  localparam int unsigned ChunkW    = rdsc_pkg::ChunkW;
  localparam int unsigned NumChunks = (VALUE_BITS + ChunkW - 1) / ChunkW;
  localparam int unsigned PadW      = NumChunks * ChunkW;
  localparam int unsigned ChunkCntW = (NumChunks > 1) ? $clog2(NumChunks) : 1;

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [ChunkCntW-1:0]         chunk_q, chunk_d;
  logic [PadW-1:0]              work_q, work_d;
  logic [rdsc_pkg::DigitW-1:0]  rem_q, rem_d;
  logic [rdsc_pkg::RadixW-1:0]  div_q, div_d;
  logic [ChunkW-1:0]            qbits;
  logic [rdsc_pkg::DigitW-1:0]  rem_step;
  logic                         last_chunk;

  always_comb begin
    logic [rdsc_pkg::DigitW:0] t;
    rem_step = rem_q;
    qbits    = '0;
    for (int i = 0; i < ChunkW; i++) begin
      t = {rem_step, work_q[PadW-1-i]};
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
        qbits[ChunkW-1-i] = 1'b1;
      end
      rem_step = t[rdsc_pkg::DigitW-1:0];
    end
  end

  assign last_chunk = (chunk_q == ChunkCntW'(NumChunks - 1));

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    chunk_d = chunk_q;
    work_d  = work_q;
    rem_d   = rem_q;
    div_d   = div_q;
    if (start_i) begin
      busy_d  = 1'b1;
      chunk_d = '0;
      work_d  = PadW'(dividend_i);
      rem_d   = '0;
      div_d   = divisor_i;
    end else if (busy_q) begin
      work_d  = (work_q << ChunkW) | PadW'(qbits);
      rem_d   = rem_step;
      chunk_d = chunk_q + ChunkCntW'(1);
      if (last_chunk) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      chunk_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      chunk_q <= chunk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = work_q[VALUE_BITS-1:0];
  assign remainder_o = rem_q;

endmodule

>>> rtl/rdsc_digit_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit string converter digit stack
// Single-port-write, registered-read memory holding the remainders.
// ----------------------------------------------------------------------------
module rdsc_digit_stack #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                               clk_i,
  input  logic                               push_i,
  input  logic [$clog2(STACK_DEPTH)-1:0]     push_addr_i,
  input  logic [rdsc_pkg::DigitW-1:0]        push_data_i,
  input  logic                               pop_i,
  input  logic [$clog2(STACK_DEPTH)-1:0]     pop_addr_i,
  output logic [rdsc_pkg::DigitW-1:0]        pop_data_o
);

  logic [rdsc_pkg::DigitW-1:0] mem_q [STACK_DEPTH];
  logic [rdsc_pkg::DigitW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[push_addr_i] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      rd_q <= mem_q[pop_addr_i];
    end
  end

  assign pop_data_o = rd_q;

endmodule

>>> rtl/radix_digit_string_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit string converter
// Converts an unsigned integer into an ASCII digit string in a chosen radix.
// ----------------------------------------------------------------------------
// Each input word is converted to its digits in the radix held in the
// configuration register (values below 2 act as 2, above 36 as 36) and the
// digits leave as ASCII characters, most significant first, the final one
// with tlast set; zero gives the single character '0'. Each division runs
// through the shared divider, which retires eight quotient bits per cycle,
// and each character takes one registered read of the digit stack memory
// plus one output load. The input is not ready while a conversion runs.
// Only the STACK_DEPTH least significant digits are kept when a value has
// more.
module radix_digit_string_converter #(
  parameter int unsigned VALUE_BITS  = 32,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration: radix.
  input  logic                              cfg_we_i,
  input  logic [rdsc_pkg::RadixW-1:0]       cfg_wdata_i,
  // Bits from low: number_value[31:0].
  input  logic [rdsc_pkg::NumW-1:0]         s_axis_tdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // Bits from low: digit_char[6:0], zero pad[7].
  output logic [rdsc_pkg::OutTdataW-1:0]    m_axis_tdata_o,
  output logic                              m_axis_tlast_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i
);

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);

  rdsc_pkg::state_e             state_q, state_d;
  logic [rdsc_pkg::RadixW-1:0]  radix_q;
  logic [rdsc_pkg::RadixW-1:0]  radix_eff;
  logic [VALUE_BITS-1:0]        value_q, value_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic                         out_valid_q, out_valid_d;
  logic [rdsc_pkg::CharW-1:0]   char_q, char_d;
  logic                         last_q, last_d;

  logic                         div_start;
  logic                         div_done;
  logic [VALUE_BITS-1:0]        div_quot;
  logic [rdsc_pkg::DigitW-1:0]  div_rem;

  logic                         push;
  logic [rdsc_pkg::DigitW-1:0]  push_data;
  logic                         pop;
  logic [rdsc_pkg::DigitW-1:0]  pop_data;
  logic                         full;
  logic                         ge_radix;
  logic                         out_free;

  always_comb begin
    if (radix_q < rdsc_pkg::RadixMin) begin
      radix_eff = rdsc_pkg::RadixMin;
    end else if (radix_q > rdsc_pkg::RadixMax) begin
      radix_eff = rdsc_pkg::RadixMax;
    end else begin
      radix_eff = radix_q;
    end
  end

  assign full     = (cnt_q == CntW'(STACK_DEPTH));
  assign ge_radix = (value_q >= VALUE_BITS'(radix_eff));
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d     = state_q;
    value_d     = value_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    char_d      = char_q;
    last_d      = last_q;
    div_start   = 1'b0;
    push        = 1'b0;
    push_data   = div_rem;
    pop         = 1'b0;
    unique case (state_q)
      rdsc_pkg::StIdle: begin
        if (s_axis_tvalid_i) begin
          value_d = VALUE_BITS'(s_axis_tdata_i);
          cnt_d   = '0;
          state_d = rdsc_pkg::StCheck;
        end
      end
      rdsc_pkg::StCheck: begin
        if (ge_radix && !full) begin
          div_start = 1'b1;
          state_d   = rdsc_pkg::StDiv;
        end else begin
          if (!full) begin
            push      = 1'b1;
            push_data = value_q[rdsc_pkg::DigitW-1:0];
            cnt_d     = cnt_q + CntW'(1);
          end
          state_d = rdsc_pkg::StRead;
        end
      end
      rdsc_pkg::StDiv: begin
        if (div_done) begin
          push      = 1'b1;
          push_data = div_rem;
          cnt_d     = cnt_q + CntW'(1);
          value_d   = div_quot;
          state_d   = rdsc_pkg::StCheck;
        end
      end
      rdsc_pkg::StRead: begin
        pop     = 1'b1;
        cnt_d   = cnt_q - CntW'(1);
        state_d = rdsc_pkg::StLoad;
      end
      rdsc_pkg::StLoad: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = rdsc_pkg::to_ascii(pop_data);
          last_d      = (cnt_q == '0);
          state_d     = (cnt_q == '0) ? rdsc_pkg::StIdle : rdsc_pkg::StRead;
        end
      end
      default: begin
        state_d = rdsc_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rdsc_pkg::StIdle;
      radix_q     <= rdsc_pkg::RadixReset;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    char_q  <= char_d;
    last_q  <= last_d;
  end

  rdsc_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (value_q),
    .divisor_i   (radix_eff),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  rdsc_digit_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i       (clk_i),
    .push_i      (push),
    .push_addr_i (cnt_q[AddrW-1:0]),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_addr_i  (cnt_d[AddrW-1:0]),
    .pop_data_o  (pop_data)
  );

  assign s_axis_tready_o = (state_q == rdsc_pkg::StIdle);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tdata_o  = {{(rdsc_pkg::OutTdataW - rdsc_pkg::CharW){1'b0}}, char_q};

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rdsc_pkg::StIdle) |-> (cnt_q == '0))
    else $error("Digit stack not empty while idle.");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (cnt_q < CntW'(STACK_DEPTH)))
    else $error("Push into a full digit stack.");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (cnt_q != '0))
    else $error("Pop from an empty digit stack.");

  a_div_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rdsc_pkg::StDiv) |-> ge_radix)
    else $error("Division running on a value below the radix.");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == rdsc_pkg::StDiv))
    else $error("Divider finished outside of a division.");

endmodule

>>> dv/radix_digit_string_converter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix digit string converter testbench
// Sends unsigned values through the converter in many radix settings,
// including the out-of-range ones that saturate. A behavioral digit
// predictor queues the expected characters, and a checker compares every
// output word against them. The sender works in bursts and the receiver
// stalls on a changing pattern.
// ----------------------------------------------------------------------------
module radix_digit_string_converter_test;

  localparam int unsigned DigitMax     = 32;
  localparam int unsigned IdleLimit    = 20000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned TailCycles   = 300;
  localparam int unsigned MaxReports   = 50;

  typedef struct packed {
    logic [rdsc_pkg::CharW-1:0] code;
    logic                       last;
  } digit_char_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [rdsc_pkg::RadixW-1:0]    cfg_wdata;
  logic [rdsc_pkg::NumW-1:0]      s_tdata;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [rdsc_pkg::OutTdataW-1:0] m_tdata;
  logic                           m_tlast;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;

  digit_char_t                 expected_chars[$];
  logic [rdsc_pkg::RadixW-1:0] radix_reg = rdsc_pkg::RadixReset;
  int                          errors = 0;
  int                          numbers_sent = 0;
  int                          chars_checked = 0;
  int                          radix_writes = 0;
  int                          burst_left = 0;
  int                          stall_mode = 0;
  int                          stall_timer = 0;
  int                          stall_count = 0;

  always #4 clk_i = ~clk_i;

  radix_digit_string_converter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready)
  );

  task automatic report_mismatch(input string msg);
    if (errors < MaxReports) begin
      $display("ERROR at %0t ns: %s", $realtime, msg);
    end
    errors++;
  endtask

  // Queues the characters of one value, most significant first.
  task automatic predict_digits(input logic [rdsc_pkg::NumW-1:0] value);
    logic [rdsc_pkg::DigitW-1:0] digits[DigitMax];
    longint unsigned             v;
    longint unsigned             base;
    int                          n;
    digit_char_t                 dc;
    v = value;
    base = radix_reg;
    n = 0;
    if (base < rdsc_pkg::RadixMin) base = rdsc_pkg::RadixMin;
    if (base > rdsc_pkg::RadixMax) base = rdsc_pkg::RadixMax;
    while (v >= base && n < DigitMax) begin
      digits[n] = rdsc_pkg::DigitW'(v % base);
      n++;
      v = v / base;
    end
    if (n < DigitMax) begin
      digits[n] = rdsc_pkg::DigitW'(v);
      n++;
    end
    for (int i = n - 1; i >= 0; i--) begin
      dc.code = (digits[i] < rdsc_pkg::DecLimit)
              ? rdsc_pkg::CharW'(digits[i]) + rdsc_pkg::CharZero
              : rdsc_pkg::CharW'(digits[i]) + rdsc_pkg::AlphaOfs;
      dc.last = (i == 0);
      expected_chars.push_back(dc);
    end
  endtask

  task automatic send_number(input logic [rdsc_pkg::NumW-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_tdata  <= value;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
    burst_left--;
    numbers_sent++;
    predict_digits(value);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_chars.size() != 0);
  endtask

  task automatic set_radix(input logic [rdsc_pkg::RadixW-1:0] value);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    radix_reg = value;
    radix_writes++;
  endtask

  function automatic logic [rdsc_pkg::NumW-1:0] random_number();
    longint unsigned p;
    longint unsigned base;
    int              k;
    base = radix_reg;
    if (base < rdsc_pkg::RadixMin) base = rdsc_pkg::RadixMin;
    if (base > rdsc_pkg::RadixMax) base = rdsc_pkg::RadixMax;
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2, 3: return $urandom >> $urandom_range(1, 31);
      4:    return $urandom_range(0, 3 * int'(base));
      5: begin
        p = 1;
        k = $urandom_range(1, 31);
        for (int i = 0; i < k; i++) begin
          if (p * base <= 64'hFFFF_FFFF) p = p * base;
        end
        return rdsc_pkg::NumW'(p - $urandom_range(0, 1));
      end
      6:    return '0;
      default: return '1;
    endcase
  endfunction

  task automatic test_directed_values();
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'd2);
    send_number(32'd3);
    send_number(32'hFFFF_FFFF);
    set_radix(6'd10);
    send_number(32'd9);
    send_number(32'd10);
    send_number(32'd100);
    send_number(32'hFFFF_FFFF);
    set_radix(6'd16);
    send_number(32'd15);
    send_number(32'd16);
    send_number(32'd255);
    send_number(32'hDEAD_BEEF);
    set_radix(6'd36);
    send_number(32'd35);
    send_number(32'd36);
    send_number(32'd1295);
    send_number(32'd0);
    send_number(32'hFFFF_FFFF);
  endtask

  task automatic test_radix_saturation();
    set_radix(6'd0);
    send_number(32'd2);
    send_number(32'd5);
    set_radix(6'd1);
    send_number(32'd2);
    set_radix(6'd37);
    send_number(32'd35);
    send_number(32'd36);
    set_radix(6'd63);
    send_number(32'd1296);
  endtask

  task automatic test_random_values();
    logic [rdsc_pkg::RadixW-1:0] phases[7];
    phases = '{6'd2, 6'd36, 6'd10, 6'd16, 6'd8, 6'd3, 6'd2};
    phases[6] = rdsc_pkg::RadixW'($urandom_range(2, 36));
    foreach (phases[p]) begin
      set_radix(phases[p]);
      for (int i = 0; i < 50; i++) begin
        send_number(random_number());
        if (i == 24) wait_drained();
      end
    end
    set_radix(rdsc_pkg::RadixW'($urandom_range(0, 63)));
    for (int i = 0; i < 10; i++) send_number(random_number());
  endtask

  always @(posedge clk_i) begin
    digit_char_t dc;
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h", m_tdata));
      end else begin
        dc = expected_chars.pop_front();
        chars_checked++;
        if (m_tdata[rdsc_pkg::CharW-1:0] !== dc.code) begin
          report_mismatch($sformatf("digit_char 0x%02h, expected 0x%02h",
                                    m_tdata[rdsc_pkg::CharW-1:0], dc.code));
        end
        if (m_tdata[rdsc_pkg::OutTdataW-1:rdsc_pkg::CharW] !== '0) begin
          report_mismatch("padding bit of tdata is not zero");
        end
        if (m_tlast !== dc.last) begin
          report_mismatch($sformatf("last_digit %b, expected %b", m_tlast, dc.last));
        end
      end
    end
    if (stall_timer == 0) begin
      stall_mode  = $urandom_range(0, 2);
      stall_timer = $urandom_range(64, 512);
    end
    stall_timer--;
    stall_count++;
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 1) == 1);
      default: m_tready <= (stall_count % 4 == 0);
    endcase
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no word moved for %0d cycles", IdleLimit);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    s_tdata   <= '0;
    s_tvalid  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_values();
    test_radix_saturation();
    test_random_values();
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    $display("Converted %0d values into %0d checked characters.", numbers_sent,
             chars_checked);
    $display("Used %0d radix writes, including saturated and extreme settings.",
             radix_writes);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
